@@ rtl/gpm_pkg.sv @@
`timescale 1ns / 1ps
package gpm_pkg;

   localparam int MAX_PATTERN = 32;
   // One position per stored byte plus the end-of-pattern position
   localparam int NPOS = MAX_PATTERN + 1;

   typedef logic [7:0] char_type;

   localparam char_type SLASH_CODE = 8'd47;
   localparam char_type STAR_CODE  = 8'd42;
   localparam char_type QMARK_CODE = 8'd63;

   localparam logic FUNC_PATTERN = 1'b0;
   localparam logic FUNC_PATH    = 1'b1;

   // Broadcast controls for the matcher row
   typedef struct packed {
      logic     load;        // pattern item accepted
      logic     restart;     // pattern item starts a new pattern
      logic     path;        // path item accepted
      logic     clear;       // active set returns to the start position
      logic     slash_char;  // current path byte is a separator
      logic     in_comp;     // within a path component
      char_type char_code;
   } ctl_type;

   // Matcher row, left to right
   typedef struct packed {
      logic head;     // only set at the left edge of the row
      logic vld;      // left neighbor holds a pattern byte
      logic slash;    // left neighbor is a separator (set at the left edge)
      logic zs;       // boundary closure through a separator
      logic zg;       // boundary closure through a globstar, one cell on
      logic zg_prev;  // same, forwarded from two cells back
      logic ys;       // star closure
      logic yl;       // literal or single wildcard consumed
   } fwd_type;

   // Matcher row, right to left
   typedef struct packed {
      logic star;
      logic bnd;
      logic bnd_next;
      logic y;
      logic y_next;
   } bwd_type;

   // Per-position snapshot for end-of-path evaluation
   typedef struct packed {
      logic act;
      logic vld;
      logic slash;
      logic star;
      logic gs;
   } snap_type;

   typedef struct packed {
      logic ys;
      logic zs;
      logic zg;
      logic zg_prev;
   } fin_fwd_type;

   typedef struct packed {
      logic y;
      logic y_next;
   } fin_bwd_type;

endpackage

@@ rtl/gpm_cell.sv @@
`timescale 1ns / 1ps
module gpm_cell
   import gpm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  ctl_type  ctl_i,
   input  fwd_type  fwd_i,
   output fwd_type  fwd_o,
   input  bwd_type  bwd_i,
   output bwd_type  bwd_o,
   output snap_type snap_o,
   output logic     cur_o
);

   char_type char_ff, char_in;
   logic     valid_ff, valid_in;
   logic     act_ff, act_in;
   logic     own_vld, wr;
   logic     is_slash, is_star, is_bnd, gs, lit;
   logic     z, y, n, k, upd;

   always_comb begin
      own_vld  = valid_ff & ~ctl_i.restart;
      wr       = ctl_i.load & fwd_i.vld & ~own_vld;
      valid_in = ctl_i.load ? (own_vld | wr) : valid_ff;
      char_in  = wr ? ctl_i.char_code : char_ff;

      is_slash = valid_ff & (char_ff == SLASH_CODE);
      is_star  = valid_ff & (char_ff == STAR_CODE);
      is_bnd   = ~valid_ff | (char_ff == SLASH_CODE);
      gs       = is_star & bwd_i.star & bwd_i.bnd_next & fwd_i.slash;
      lit      = valid_ff & (char_ff != SLASH_CODE) & (char_ff != STAR_CODE)
                 & ((char_ff == QMARK_CODE) | (char_ff == ctl_i.char_code));

      // boundary closure only when a new component starts
      z   = act_ff | (~ctl_i.in_comp & (fwd_i.zs | fwd_i.zg_prev));
      y   = z | fwd_i.ys;
      n   = (y & is_star) | fwd_i.yl;
      k   = (y & is_bnd) | (gs & bwd_i.y_next);
      upd = ctl_i.slash_char ? (ctl_i.in_comp ? k : act_ff) : n;

      act_in = ctl_i.clear ? fwd_i.head : (ctl_i.path ? upd : act_ff);
   end

   always_comb begin
      fwd_o.head    = 1'b0;
      fwd_o.vld     = own_vld;
      fwd_o.slash   = is_slash;
      fwd_o.zs      = z & is_slash;
      fwd_o.zg      = z & gs;
      fwd_o.zg_prev = fwd_i.zg;
      fwd_o.ys      = y & is_star;
      fwd_o.yl      = y & lit;

      bwd_o.star     = is_star;
      bwd_o.bnd      = is_bnd;
      bwd_o.bnd_next = bwd_i.bnd;
      bwd_o.y        = y;
      bwd_o.y_next   = bwd_i.y;

      snap_o.act   = upd;
      snap_o.vld   = valid_ff;
      snap_o.slash = is_slash;
      snap_o.star  = is_star;
      snap_o.gs    = gs;
      cur_o        = act_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         act_ff   <= fwd_i.head;
      end else begin
         valid_ff <= valid_in;
         act_ff   <= act_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
   end

endmodule

@@ rtl/gpm_fin_cell.sv @@
`timescale 1ns / 1ps
module gpm_fin_cell
   import gpm_pkg::*;
(
   input  logic        clock,
   input  logic        cap,
   input  logic        in_comp,
   input  snap_type    snap_i,
   input  fin_fwd_type fwd_i,
   output fin_fwd_type fwd_o,
   input  fin_bwd_type bwd_i,
   output fin_bwd_type bwd_o,
   output logic        hit_o
);

   snap_type s_ff, s_in;
   logic     y, bnd, k, z;

   always_comb begin
      s_in = cap ? snap_i : s_ff;
      // close the open component first, then skip separators and empty globstars
      y   = s_ff.act | (in_comp & fwd_i.ys);
      bnd = ~s_ff.vld | s_ff.slash;
      k   = in_comp ? ((y & bnd) | (s_ff.gs & bwd_i.y_next)) : s_ff.act;
      z   = k | fwd_i.zs | fwd_i.zg_prev;

      fwd_o.ys      = y & s_ff.star;
      fwd_o.zs      = z & s_ff.slash;
      fwd_o.zg      = z & s_ff.gs;
      fwd_o.zg_prev = fwd_i.zg;
      bwd_o.y       = y;
      bwd_o.y_next  = bwd_i.y;
      hit_o         = z & ~s_ff.vld;
   end

   always_ff @(posedge clock) begin
      s_ff <= s_in;
   end

endmodule

@@ rtl/glob_path_matcher.sv @@
`timescale 1ns / 1ps
// Each verdict passes the evaluation row, then the output register that drives rsp.
// Throughput: one item per cycle while req_stall is low; the active set of all
// pattern positions advances by a ripple along the row of MAX_PATTERN + 1 matcher cells.
// Two result slots (evaluation row, output register) absorb backpressure.
// Reset (synchronous): empty pattern, overflow clear, active set at the start position;
// pattern bytes are undefined until loaded again.
module glob_path_matcher
   import gpm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  logic     req_func,
   input  char_type req_char_code,
   input  logic     req_last,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output logic     rsp_matched,
   output logic     rsp_pattern_overflow
);

   // Request side control
   logic    req_acc, load, path, capture, slash_char, full;
   ctl_type ctl;

   logic loading_done_ff, loading_done_in;
   logic ovf_ff, ovf_in;
   logic inside_ff, inside_in;

   // Evaluation slot
   logic fin_vld_ff, fin_vld_in;
   logic fin_inside_ff, fin_inside_in;
   logic fin_ovf_ff, fin_ovf_in;
   logic fin_move, fin_free, out_free, hit;

   // Output register
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_matched_ff, rsp_matched_in;
   logic rsp_ovf_ff, rsp_ovf_in;

   // Cell rows
   fwd_type     fwd [NPOS+1];
   bwd_type     bwd [NPOS+1];
   snap_type    snap [NPOS];
   fin_fwd_type ffwd [NPOS+1];
   fin_bwd_type fbwd [NPOS+1];
   logic [NPOS-1:0] cur_vec, vld_vec, hit_vec;

   // Edge ties: position 0 is the start and counts as following a separator;
   // past the end nothing is a star and everything is a component end.
   always_comb begin
      fwd[0]         = '0;
      fwd[0].head    = 1'b1;
      fwd[0].vld     = 1'b1;
      fwd[0].slash   = 1'b1;
      bwd[NPOS]      = '0;
      bwd[NPOS].bnd      = 1'b1;
      bwd[NPOS].bnd_next = 1'b1;
      ffwd[0]        = '0;
      fbwd[NPOS]     = '0;
   end

   // Hold the whole request side when both result slots are taken
   always_comb begin
      out_free   = ~rsp_valid_ff | ~rsp_stall;
      fin_move   = fin_vld_ff & out_free;
      fin_free   = ~fin_vld_ff | out_free;
      req_stall  = ~fin_free;
      req_acc    = req_valid & ~req_stall;
      load       = req_acc & (req_func == FUNC_PATTERN);
      path       = req_acc & (req_func == FUNC_PATH);
      capture    = path & req_last;
      slash_char = (req_char_code == SLASH_CODE);
      // Last storage cell already taken: this byte marks the pattern as overflowed
      full       = fwd[MAX_PATTERN].vld;

      ctl.load       = load;
      ctl.restart    = load & loading_done_ff;
      ctl.path       = path;
      ctl.clear      = load | capture;
      ctl.slash_char = slash_char;
      ctl.in_comp    = inside_ff;
      ctl.char_code  = req_char_code;
   end

   always_comb begin
      loading_done_in = load ? req_last : loading_done_ff;
      ovf_in          = load ? ((ovf_ff & ~loading_done_ff) | full) : ovf_ff;
      // Pattern items and finished paths drop the component state; a separator ends it
      if (load) begin
         inside_in = 1'b0;
      end else if (path) begin
         inside_in = ~req_last & ~slash_char;
      end else begin
         inside_in = inside_ff;
      end

      fin_vld_in    = capture | (fin_vld_ff & ~fin_move);
      fin_inside_in = capture ? ~slash_char : fin_inside_ff;
      fin_ovf_in    = capture ? ovf_ff : fin_ovf_ff;

      hit            = |hit_vec;
      rsp_valid_in   = fin_move | (rsp_valid_ff & rsp_stall);
      rsp_matched_in = fin_move ? (hit & ~fin_ovf_ff) : rsp_matched_ff;
      rsp_ovf_in     = fin_move ? fin_ovf_ff : rsp_ovf_ff;
   end

   // Matcher row: pattern store and active set, one cell per position
   // Evaluation row: snapshot at the last path byte, closes the final component
   for (genvar g = 0; g < NPOS; g++) begin : g_pos
      gpm_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .ctl_i  (ctl),
         .fwd_i  (fwd[g]),
         .fwd_o  (fwd[g+1]),
         .bwd_i  (bwd[g+1]),
         .bwd_o  (bwd[g]),
         .snap_o (snap[g]),
         .cur_o  (cur_vec[g])
      );

      gpm_fin_cell u_fin (
         .clock   (clock),
         .cap     (capture),
         .in_comp (fin_inside_ff),
         .snap_i  (snap[g]),
         .fwd_i   (ffwd[g]),
         .fwd_o   (ffwd[g+1]),
         .bwd_i   (fbwd[g+1]),
         .bwd_o   (fbwd[g]),
         .hit_o   (hit_vec[g])
      );

      assign vld_vec[g] = snap[g].vld;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loading_done_ff <= 1'b1;
         ovf_ff          <= 1'b0;
         inside_ff       <= 1'b0;
         fin_vld_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         loading_done_ff <= loading_done_in;
         ovf_ff          <= ovf_in;
         inside_ff       <= inside_in;
         fin_vld_ff      <= fin_vld_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_inside_ff  <= fin_inside_in;
      fin_ovf_ff     <= fin_ovf_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_ovf_ff     <= rsp_ovf_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_matched          = rsp_matched_ff;
   assign rsp_pattern_overflow = rsp_ovf_ff;

   // Stored bytes always form a prefix of the row
   a_store_prefix: assert property (@(posedge clock) disable iff (reset)
      (NPOS'(vld_vec + NPOS'(1)) & vld_vec) == '0)
      else $error("pattern store is not a prefix");

   // At most one live position lies at or past the pattern end
   a_end_single: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cur_vec & ~vld_vec))
      else $error("live position past the pattern end");

   // A pattern item leaves the path outside any component
   a_load_clears: assert property (@(posedge clock) disable iff (reset)
      load |=> !inside_ff)
      else $error("component state kept across a pattern item");

   // A finished path always lands in the evaluation slot
   a_capture: assert property (@(posedge clock) disable iff (reset)
      capture |=> fin_vld_ff)
      else $error("finished path lost");

endmodule

@@ verif/tb_glob_path_matcher.sv @@
`timescale 1ns / 1ps
module tb_glob_path_matcher;
   import gpm_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 1250;
   localparam int QUIET_TAIL   = 150;

   typedef struct {
      logic     func;
      char_type code;
      logic     last;
      bit       drain;   // hold this item back until every verdict has come
   } req_item_type;

   typedef struct {
      logic matched;
      logic overflow;
   } verdict_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_stall;
   logic     req_func = FUNC_PATTERN;
   char_type req_char_code = '0;
   logic     req_last = 1'b0;
   logic     rsp_valid;
   logic     rsp_stall = 1'b0;
   logic     rsp_matched;
   logic     rsp_pattern_overflow;

   glob_path_matcher dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_func             (req_func),
      .req_char_code        (req_char_code),
      .req_last             (req_last),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_matched          (rsp_matched),
      .rsp_pattern_overflow (rsp_pattern_overflow)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   req_item_type pending_items[$];
   verdict_type  expected_verdicts[$];

   int n_errors     = 0;
   int n_accepted   = 0;
   int n_checked    = 0;
   int n_hits       = 0;
   int n_ovf_checks = 0;
   int n_patterns   = 0;
   int cycle_count  = 0;

   // ------------------------------------------------------------------
   // Matcher prediction: stored pattern plus the set of live positions.
   // Bit p of live_set means pattern position p (0..pat_len) can be next.
   // ------------------------------------------------------------------
   char_type    pat_mem [0:MAX_PATTERN-1];
   int unsigned pat_len;
   bit          pat_closed;
   bit          pat_ovf;
   bit          in_comp;
   logic [63:0] live_set;

   // "**" standing alone as a pattern component
   function automatic bit globstar_at(int unsigned p);
      if (p + 1 >= pat_len) return 1'b0;
      if (pat_mem[p] != STAR_CODE || pat_mem[p+1] != STAR_CODE) return 1'b0;
      if (p + 2 < pat_len && pat_mem[p+2] != SLASH_CODE) return 1'b0;
      if (p > 0 && pat_mem[p-1] != SLASH_CODE) return 1'b0;
      return 1'b1;
   endfunction

   // Skip pattern separators and let a globstar match zero components;
   // every step moves forward, so one ascending pass is enough.
   function automatic void skip_boundary();
      int unsigned p;
      for (p = 0; p < pat_len; p++) begin
         if (!live_set[p]) continue;
         if (pat_mem[p] == SLASH_CODE) live_set[p+1] = 1'b1;
         else if (globstar_at(p)) live_set[p+2] = 1'b1;
      end
   endfunction

   // A star may match an empty run
   function automatic void open_stars();
      int unsigned p;
      for (p = 0; p < pat_len; p++)
         if (live_set[p] && pat_mem[p] == STAR_CODE) live_set[p+1] = 1'b1;
   endfunction

   function automatic void consume_char(char_type c);
      logic [63:0] nxt;
      int unsigned p;
      nxt = '0;
      open_stars();
      for (p = 0; p < pat_len; p++) begin
         if (!live_set[p] || pat_mem[p] == SLASH_CODE) continue;
         if (pat_mem[p] == STAR_CODE) nxt[p] = 1'b1;
         else if (pat_mem[p] == QMARK_CODE || pat_mem[p] == c) nxt[p+1] = 1'b1;
      end
      live_set = nxt;
   endfunction

   // Keep positions at a pattern component end; a globstar that just took a
   // whole component stays live for more.
   function automatic void close_component();
      logic [63:0] kept;
      int unsigned q;
      kept = '0;
      open_stars();
      for (q = 0; q <= pat_len; q++) begin
         if (!live_set[q]) continue;
         if (q < pat_len && pat_mem[q] != SLASH_CODE) continue;
         kept[q] = 1'b1;
         if (q >= 2 && globstar_at(q - 2)) kept[q-2] = 1'b1;
      end
      live_set = kept;
      in_comp  = 1'b0;
   endfunction

   task automatic apply_item(input logic f, input char_type c, input logic l);
      verdict_type v;
      if (f == FUNC_PATTERN) begin
         // a pattern byte restarts after a finished pattern, and drops any path
         if (pat_closed) begin
            pat_len    = 0;
            pat_ovf    = 1'b0;
            pat_closed = 1'b0;
         end
         if (pat_len < MAX_PATTERN) begin
            pat_mem[pat_len] = c;
            pat_len++;
         end else begin
            pat_ovf = 1'b1;
         end
         if (l) pat_closed = 1'b1;
         live_set = 64'd1;
         in_comp  = 1'b0;
      end else begin
         if (c == SLASH_CODE) begin
            if (in_comp) close_component();
         end else begin
            if (!in_comp) begin
               skip_boundary();
               in_comp = 1'b1;
            end
            consume_char(c);
         end
         if (l) begin
            if (in_comp) close_component();
            skip_boundary();
            v.matched  = live_set[pat_len] && !pat_ovf;
            v.overflow = pat_ovf;
            expected_verdicts.insert(expected_verdicts.size(), v);
            live_set = 64'd1;
            in_comp  = 1'b0;
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Stimulus building
   // ------------------------------------------------------------------
   function automatic void append_char(ref char_type q[$], input char_type c);
      q.insert(q.size(), c);
   endfunction

   task automatic add_item(input logic f, input char_type c, input logic l, input bit d);
      req_item_type it;
      it.func  = f;
      it.code  = c;
      it.last  = l;
      it.drain = d;
      pending_items.insert(pending_items.size(), it);
   endtask

   task automatic add_text(input logic f, input string s, input bit end_mark, input bit d);
      for (int i = 0; i < s.len(); i++)
         add_item(f, s[i], end_mark && (i == s.len() - 1), d && (i == 0));
   endtask

   task automatic add_seq(input logic f, input char_type s[$], input bit end_mark,
                          input bit d);
      for (int i = 0; i < s.size(); i++)
         add_item(f, s[i], end_mark && (i == s.size() - 1), d && (i == 0));
   endtask

   function automatic char_type letter();
      return char_type'(8'h61 + $urandom_range(0, 2));
   endfunction

   function automatic char_type pattern_char();
      int unsigned r;
      r = $urandom_range(0, 11);
      if (r < 5) return letter();
      if (r < 8) return STAR_CODE;
      if (r < 10) return QMARK_CODE;
      if (r == 10) return char_type'($urandom_range(0, 255));
      return SLASH_CODE;
   endfunction

   // Mostly a few short components with wildcards and globstars; now and
   // then a long one that may run past the store.
   task automatic gen_pattern(output char_type p[$]);
      int unsigned n_comp, n_chr;
      p = {};
      if ($urandom_range(0, 19) == 0) begin
         n_chr = $urandom_range(28, 40);
         repeat (n_chr) append_char(p, pattern_char());
      end else begin
         if ($urandom_range(0, 4) == 0) append_char(p, SLASH_CODE);
         n_comp = $urandom_range(1, 4);
         for (int k = 0; k < n_comp; k++) begin
            if (k > 0) begin
               append_char(p, SLASH_CODE);
               if ($urandom_range(0, 5) == 0) append_char(p, SLASH_CODE);
            end
            if ($urandom_range(0, 4) == 0) begin
               append_char(p, STAR_CODE);
               append_char(p, STAR_CODE);
            end else begin
               n_chr = $urandom_range(1, 4);
               repeat (n_chr) append_char(p, pattern_char());
            end
         end
         if ($urandom_range(0, 5) == 0) append_char(p, SLASH_CODE);
      end
   endtask

   // Build a path that the pattern should match, then sometimes spoil it
   task automatic gen_path(input char_type pat[$], output char_type path[$]);
      int unsigned i, n, idx;
      char_type c;
      path = {};
      i = 0;
      if ($urandom_range(0, 3) == 0) append_char(path, SLASH_CODE);
      while (i < pat.size()) begin
         c = pat[i];
         if (c == SLASH_CODE) begin
            append_char(path, SLASH_CODE);
            if ($urandom_range(0, 2) == 0) append_char(path, SLASH_CODE);
            i++;
         end else if (c == STAR_CODE && i + 1 < pat.size() && pat[i+1] == STAR_CODE &&
                      (i == 0 || pat[i-1] == SLASH_CODE) &&
                      (i + 2 == pat.size() || pat[i+2] == SLASH_CODE)) begin
            n = $urandom_range(0, 2);
            repeat (n) begin
               repeat ($urandom_range(1, 3)) append_char(path, letter());
               append_char(path, SLASH_CODE);
            end
            i += 2;
         end else if (c == STAR_CODE) begin
            repeat ($urandom_range(0, 3)) append_char(path, letter());
            i++;
         end else if (c == QMARK_CODE) begin
            append_char(path, letter());
            i++;
         end else begin
            append_char(path, c);
            i++;
         end
      end
      if ($urandom_range(0, 3) == 0) append_char(path, SLASH_CODE);
      if (path.size() > 0 && $urandom_range(0, 2) == 0) begin
         idx = $urandom_range(0, path.size() - 1);
         path[idx] = ($urandom_range(0, 1) == 0) ? letter()
                                                : char_type'($urandom_range(0, 255));
      end
      if (path.size() == 0) append_char(path, SLASH_CODE);
   endtask

   task automatic gen_noise(output char_type path[$]);
      int unsigned r;
      path = {};
      repeat ($urandom_range(1, 6)) begin
         r = $urandom_range(0, 3);
         if (r == 0) append_char(path, SLASH_CODE);
         else if (r == 1) append_char(path, char_type'($urandom_range(0, 255)));
         else append_char(path, letter());
      end
   endtask

   task automatic fill_random();
      char_type cur_pat[$], seq[$], part[$], path[$];
      int unsigned r, k;
      bit need_pattern, d;
      need_pattern = 1'b1;
      cur_pat = {};
      while (pending_items.size() < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         d = ($urandom_range(0, 39) == 0);
         if (need_pattern || r < 15) begin
            gen_pattern(seq);
            add_seq(FUNC_PATTERN, seq, 1'b1, d);
            cur_pat = seq;
            n_patterns++;
            need_pattern = 1'b0;
         end else if (r < 20) begin
            // pattern left open, a path against the prefix, then the rest
            gen_pattern(seq);
            k = $urandom_range(1, seq.size());
            part = {};
            for (int i = 0; i < k; i++) append_char(part, seq[i]);
            add_seq(FUNC_PATTERN, part, 1'b0, d);
            gen_path(part, path);
            add_seq(FUNC_PATH, path, 1'b1, 1'b0);
            cur_pat = part;
            part = {};
            for (int i = k; i < seq.size(); i++) append_char(part, seq[i]);
            if (part.size() == 0) append_char(part, letter());
            add_seq(FUNC_PATTERN, part, 1'b1, 1'b0);
            foreach (part[i]) append_char(cur_pat, part[i]);
            n_patterns++;
         end else if (r < 25) begin
            // path cut short by a new pattern
            gen_path(cur_pat, path);
            add_seq(FUNC_PATH, path, 1'b0, d);
            need_pattern = 1'b1;
         end else if (r < 32) begin
            gen_noise(path);
            add_seq(FUNC_PATH, path, 1'b1, d);
         end else begin
            gen_path(cur_pat, path);
            add_seq(FUNC_PATH, path, 1'b1, d);
         end
      end
      // close on a path so the run ends with a verdict
      gen_path(cur_pat, path);
      add_seq(FUNC_PATH, path, 1'b1, 1'b0);
   endtask

   // ------------------------------------------------------------------
   // Driver: present queued items, idle in bursts, hold off for drains
   // ------------------------------------------------------------------
   req_item_type next_item;
   int           send_gap  = 0;
   int           send_calm = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // the item on the port was taken at this edge
         if (req_valid && !req_stall) begin
            apply_item(req_func, req_char_code, req_last);
            n_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (send_calm > 0) send_calm--;
            else if ($urandom_range(0, 40) == 0) send_calm = $urandom_range(20, 80);
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_items.size() == 0) begin
               req_valid <= 1'b0;
            end else if (pending_items[0].drain && expected_verdicts.size() != 0) begin
               // hold off until every verdict owed so far has come back
               req_valid <= 1'b0;
            end else if (pending_items.size() > QUIET_TAIL && send_calm == 0 &&
                         $urandom_range(0, 11) == 0) begin
               send_gap  = $urandom_range(1, 18) - 1;
               req_valid <= 1'b0;
            end else begin
               next_item = pending_items.pop_front();
               req_valid     <= 1'b1;
               req_func      <= next_item.func;
               req_char_code <= next_item.code;
               req_last      <= next_item.last;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: check each verdict against the oldest expectation and
   // stall the result side in bursts
   // ------------------------------------------------------------------
   verdict_type want;
   int          stall_left = 0;
   int          recv_calm  = 0;

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      n_errors++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_verdicts.size() == 0) begin
               report_mismatch("verdict with no path pending");
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_matched !== want.matched)
                  report_mismatch($sformatf("verdict %0d matched %b, want %b",
                                            n_checked, rsp_matched, want.matched));
               if (rsp_pattern_overflow !== want.overflow)
                  report_mismatch($sformatf("verdict %0d pattern_overflow %b, want %b",
                                            n_checked, rsp_pattern_overflow,
                                            want.overflow));
               if (want.matched) n_hits++;
               if (want.overflow) n_ovf_checks++;
               n_checked++;
            end
         end
         if (recv_calm > 0) recv_calm--;
         else if ($urandom_range(0, 40) == 0) recv_calm = $urandom_range(20, 80);
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (pending_items.size() > QUIET_TAIL && recv_calm == 0 &&
                      $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 18) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: drop the run if it hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d verdicts still owed",
                  cycle_count, expected_verdicts.size());
         $display("FAIL glob_path_matcher");
         $finish;
      end
   end

   initial begin
      foreach (pat_mem[i]) pat_mem[i] = '0;
      pat_len    = 0;
      pat_closed = 1'b1;
      pat_ovf    = 1'b0;
      in_comp    = 1'b0;
      live_set   = 64'd1;

      // Directed: star and single wildcard across a doubled separator
      add_text(FUNC_PATTERN, "a*/?", 1'b1, 1'b0);
      add_text(FUNC_PATH, "ab//c", 1'b1, 1'b0);
      // globstar against the empty path
      add_text(FUNC_PATTERN, "**", 1'b1, 1'b0);
      add_item(FUNC_PATH, SLASH_CODE, 1'b1, 1'b0);
      // path while the pattern is still open, then append to it
      add_text(FUNC_PATTERN, "x", 1'b0, 1'b0);
      add_text(FUNC_PATH, "x", 1'b1, 1'b0);
      add_text(FUNC_PATTERN, "y", 1'b1, 1'b0);
      add_text(FUNC_PATH, "xy", 1'b1, 1'b0);
      // pattern byte abandons a path under way; extreme byte values
      add_item(FUNC_PATH, "x", 1'b0, 1'b0);
      add_item(FUNC_PATTERN, 8'hFF, 1'b1, 1'b0);
      add_item(FUNC_PATH, 8'h00, 1'b1, 1'b0);
      add_item(FUNC_PATH, 8'hFF, 1'b1, 1'b0);
      // literal star in the path still meets a wildcard
      add_text(FUNC_PATTERN, "*", 1'b1, 1'b0);
      add_text(FUNC_PATH, "*", 1'b1, 1'b0);

      // first random item waits for the directed verdicts to drain
      add_item(FUNC_PATTERN, "a", 1'b1, 1'b1);
      fill_random();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // advance until every item is taken and every verdict checked
      while (pending_items.size() != 0 || req_valid || expected_verdicts.size() != 0)
         @(negedge clock);
      repeat (8) @(posedge clock);

      $display("%0d items sent over %0d patterns, %0d verdicts checked",
               n_accepted, n_patterns, n_checked);
      $display("%0d verdicts matched, %0d came from an overflowed pattern",
               n_hits, n_ovf_checks);
      if (n_errors == 0) begin
         $display("PASS glob_path_matcher");
      end else begin
         $display("FAIL glob_path_matcher");
      end
      $finish;
   end

endmodule
